### rtl/ksfla_pkg.sv
// shared types and constants for the key slot free list allocator
`default_nettype none

package ksfla_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 6;
  localparam int DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/ksfla_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module ksfla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/ksfla_ctrl.sv
// controller: sequences accept, execute and result beats
`default_nettype none

module ksfla_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ksfla_pkg::dp_cmd_t     cmd
);

  import ksfla_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.commit  = commit;

endmodule

`default_nettype wire

### rtl/ksfla_dp.sv
// datapath: slot memory, free list head, high-water count and result registers
`default_nettype none

module ksfla_dp #(
  parameter int KEY_SLOTS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ksfla_pkg::dp_cmd_t              cmd,
  input  wire logic [ksfla_pkg::OP_W-1:0]      in_operation,
  input  wire logic [ksfla_pkg::KEY_W-1:0]     in_key,
  input  wire logic [ksfla_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_status,
  output logic      [ksfla_pkg::KEY_W-1:0]     out_new_key,
  output logic      [ksfla_pkg::DATA_W-1:0]    out_read_value
);

  import ksfla_pkg::*;

  localparam int AW    = $clog2(KEY_SLOTS);
  localparam int CNT_W = $clog2(KEY_SLOTS + 1);
  localparam int MEM_W = (VALUE_BITS > CNT_W) ? VALUE_BITS : CNT_W;
  localparam int CMP_W = (CNT_W > KEY_W) ? CNT_W : KEY_W;

  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  value_r;
  logic [CNT_W-1:0]   used_count_r, used_count_nxt;
  logic [CNT_W-1:0]   free_head_r, free_head_nxt;
  logic               status_r, status_nxt;
  logic [KEY_W-1:0]   new_key_r, new_key_nxt;
  logic [DATA_W-1:0]  read_value_r, read_value_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [MEM_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [MEM_W-1:0]   ram_rdata;

  logic [CMP_W-1:0]   key_cmp;
  logic [CMP_W-1:0]   used_cmp;
  logic               key_in_table;
  logic               key_in_use;
  logic               list_nonempty;
  logic               link_valid;

  // pop reads the head slot, everything else reads the addressed key
  assign ram_raddr = (op_t'(in_operation) == OP_CREATE) ? AW'(free_head_r) : AW'(in_key);

  ksfla_ram #(
    .WIDTH (MEM_W),
    .DEPTH (KEY_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_cmp       = CMP_W'(key_r);
  assign used_cmp      = CMP_W'(used_count_r);
  assign key_in_table  = key_cmp < CMP_W'(KEY_SLOTS);
  assign key_in_use    = key_cmp < used_cmp;
  assign list_nonempty = free_head_r < used_count_r;
  assign link_valid    = ram_rdata < MEM_W'(used_count_r);

  always_comb begin
    used_count_nxt = used_count_r;
    free_head_nxt  = free_head_r;
    status_nxt     = ST_OK;
    new_key_nxt    = '0;
    read_value_nxt = '0;
    ram_we         = 1'b0;
    ram_waddr      = AW'(key_r);
    ram_wdata      = MEM_W'(VALUE_BITS'(value_r));
    unique case (op_r)
      OP_CREATE: begin
        if (list_nonempty) begin
          new_key_nxt   = KEY_W'(free_head_r);
          free_head_nxt = link_valid ? CNT_W'(ram_rdata) : used_count_r;
        end else if (used_count_r == CNT_W'(KEY_SLOTS)) begin
          status_nxt = ST_FULL;
        end else begin
          new_key_nxt    = KEY_W'(used_count_r);
          used_count_nxt = used_count_r + CNT_W'(1);
          free_head_nxt  = used_count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        // a delete while the count is one collapses the table back to empty
        if (used_count_r == CNT_W'(1)) begin
          used_count_nxt = '0;
          free_head_nxt  = '0;
        end else if (key_in_use) begin
          ram_we        = 1'b1;
          ram_wdata     = MEM_W'(free_head_r);
          free_head_nxt = CNT_W'(key_r);
        end
      end
      OP_SET: begin
        ram_we = key_in_table;
      end
      OP_GET: begin
        if (key_in_table) begin
          read_value_nxt = DATA_W'(ram_rdata);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (!cmd.commit) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_count_r <= '0;
      free_head_r  <= '0;
    end else if (cmd.commit) begin
      used_count_r <= used_count_nxt;
      free_head_r  <= free_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_operation);
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (cmd.commit) begin
      status_r     <= status_nxt;
      new_key_r    <= new_key_nxt;
      read_value_r <= read_value_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_new_key    = new_key_r;
  assign out_read_value = read_value_r;

endmodule

`default_nettype wire

### rtl/key_slot_free_list_allocator.sv
// top level of the key slot free list allocator
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_ready    | in_operation, in_key, in_value
//   out      | out_valid / out_ready  | out_status, out_new_key, out_read_value
//
// each operation has an accept beat, which issues the slot memory read (free list
// head for create, key for the rest), and an execute beat, which uses the read
// data, updates head, count or slot and loads the result register.
// reset clears the count, the head, the state and out_valid; slot contents are not
// cleared. a result waiting on out_ready does not block the next accept, but the
// following item holds in execute until the result register is taken.
`default_nettype none

module key_slot_free_list_allocator #(
  parameter int KEY_SLOTS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ksfla_pkg::OP_W-1:0]      in_operation,
  input  wire logic [ksfla_pkg::KEY_W-1:0]     in_key,
  input  wire logic [ksfla_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_status,
  output logic      [ksfla_pkg::KEY_W-1:0]     out_new_key,
  output logic      [ksfla_pkg::DATA_W-1:0]    out_read_value
);

  import ksfla_pkg::*;

  dp_cmd_t cmd;

  ksfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ksfla_dp #(
    .KEY_SLOTS  (KEY_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_new_key    (out_new_key),
    .out_read_value (out_read_value)
  );

endmodule

`default_nettype wire
